FILE: design/brb_pkg.sv
// ----------------------------------------------------------------------------
// brb_pkg
// shared types, codes and defaults for the byte ring buffer core
// ----------------------------------------------------------------------------
`default_nettype none

package brb_pkg;

	localparam int DEPTH_DEFAULT     = 256;
	localparam int MAX_BLOCK_DEFAULT = 8;

	localparam int ACTION_W = 3;
	localparam int WORD_W   = 64;
	localparam int OFFSET_W = 8;
	localparam int LEN_W    = 4;
	localparam int STATUS_W = 2;
	localparam int FILL_W   = 8;
	localparam int BYTE_W   = 8;

	// request actions
	localparam logic [ACTION_W-1:0] ACT_READ        = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_WRITE       = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_PEEK        = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_BLOCK_READ  = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_BLOCK_WRITE = 3'd4;

	// result status
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [WORD_W-1:0]   data_word;
		logic [OFFSET_W-1:0] offset;
		logic [LEN_W-1:0]    block_length;
	} brb_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [WORD_W-1:0]   read_word;
		logic [FILL_W-1:0]   fill_level;
	} brb_rsp_t;

endpackage

`default_nettype wire

FILE: design/byte_ring_buffer_with_peek_and_blocks_core.sv
// ----------------------------------------------------------------------------
// byte_ring_buffer_with_peek_and_blocks_core
// byte ring buffer with single, peek and block accesses over one ram port pair
// ----------------------------------------------------------------------------
// usage
//   a request is taken at a rising edge with start high and busy low. it asks
//   for a single read, single write, peek, block read or block write. block
//   bytes are packed in data_word / read_word with the first byte lowest.
//   the buffer holds at most DEPTH-1 bytes.
//   every request gives exactly one result: done is high for one cycle with
//   rsp valid in that same cycle. the receiver cannot stall, so results are
//   never held back.
// timing
//   a request that fails its check, has zero length or an unknown action
//   gives its result in the next cycle and busy never rises.
//   a read, peek or block read of n bytes keeps busy high while one byte per
//   cycle leaves the ram and the last byte passes the read data register,
//   and shows done in the first cycle with busy low.
//   a write or block write of n bytes keeps busy high for its ram writes, one
//   per cycle, then done follows in the first cycle with busy low.
//   a new request can be taken in the same cycle that done is shown.
// reset
//   both pointers go to zero, so the buffer is empty. the ram is not cleared;
//   only bytes that were written are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_ring_buffer_with_peek_and_blocks_core #(
	parameter int DEPTH     = brb_pkg::DEPTH_DEFAULT,
	parameter int MAX_BLOCK = brb_pkg::MAX_BLOCK_DEFAULT
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire brb_pkg::brb_req_t req,
	output logic                   busy,
	output logic                   done,
	output brb_pkg::brb_rsp_t      rsp
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int EXT_W = (PTR_W > brb_pkg::FILL_W) ? PTR_W : brb_pkg::FILL_W;
	localparam int IDX_W = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
	localparam int LEN_W = brb_pkg::LEN_W;
	localparam int BYTE_W = brb_pkg::BYTE_W;
	localparam int WORD_W = brb_pkg::WORD_W;

	// sequencer states
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RD   = 2'd1;
	localparam logic [1:0] S_LAST = 2'd2;
	localparam logic [1:0] S_WR   = 2'd3;

	logic [1:0]        state_q;
	logic [PTR_W-1:0]  rp_q;
	logic [PTR_W-1:0]  wp_q;
	logic [PTR_W-1:0]  addr_q;
	logic [IDX_W-1:0]  cnt_q;
	logic [LEN_W-1:0]  len_q;
	logic [PTR_W-1:0]  fill_q;
	logic [WORD_W-1:0] data_q;
	logic [WORD_W-1:0] word_q;
	logic              upd_q;
	logic              done_q;
	brb_pkg::brb_rsp_t rsp_q;

	// read data pipeline: the ram read is registered, so data comes back in the cycle after the address
	logic              rvalid_s1;
	logic [IDX_W-1:0]  ridx_s1;
	logic [BYTE_W-1:0] rdata;

	logic                           accept;
	logic [brb_pkg::ACTION_W-1:0]   act;
	logic                           rd_op;
	logic                           wr_op;
	logic                           is_peek;
	logic [LEN_W-1:0]               blk_len;
	logic [LEN_W-1:0]               len_eff;
	logic [PTR_W-1:0]               fill;
	logic [EXT_W-1:0]               fill_ext;
	logic [brb_pkg::STATUS_W-1:0]   chk_status;
	logic                           last_step;
	logic [WORD_W-1:0]              word_merged;
	logic [BYTE_W-1:0]              wbyte;
	logic [EXT_W-1:0]               fill_rd_ext;
	logic [EXT_W-1:0]               fill_wr_ext;

	logic [PTR_W-1:0]               alu_base;
	logic [brb_pkg::OFFSET_W-1:0]   alu_step;
	logic [PTR_W-1:0]               alu_sum;

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign rsp    = rsp_q;
	assign accept = start && !busy;

	// request decode
	assign act     = req.action;
	assign is_peek = (act == brb_pkg::ACT_PEEK);
	assign rd_op   = (act == brb_pkg::ACT_READ) || is_peek ||
	                 (act == brb_pkg::ACT_BLOCK_READ);
	assign wr_op   = (act == brb_pkg::ACT_WRITE) || (act == brb_pkg::ACT_BLOCK_WRITE);
	assign blk_len = (req.block_length > LEN_W'(MAX_BLOCK)) ? LEN_W'(MAX_BLOCK)
	                                                        : req.block_length;

	always_comb begin
		len_eff = LEN_W'(1);
		if ((act == brb_pkg::ACT_BLOCK_READ) || (act == brb_pkg::ACT_BLOCK_WRITE)) begin
			len_eff = blk_len;
		end
	end

	// stored byte count, modulo depth
	assign fill     = wp_q - rp_q;
	assign fill_ext = EXT_W'(fill);

	always_comb begin
		chk_status = brb_pkg::ST_OK;
		case (act)
			brb_pkg::ACT_READ: begin
				if (fill == '0) chk_status = brb_pkg::ST_EMPTY;
			end
			brb_pkg::ACT_WRITE: begin
				if (fill_ext == EXT_W'(DEPTH - 1)) chk_status = brb_pkg::ST_FULL;
			end
			brb_pkg::ACT_PEEK: begin
				if (fill_ext <= EXT_W'(req.offset)) chk_status = brb_pkg::ST_EMPTY;
			end
			brb_pkg::ACT_BLOCK_READ: begin
				if (fill_ext < EXT_W'(blk_len)) chk_status = brb_pkg::ST_EMPTY;
			end
			brb_pkg::ACT_BLOCK_WRITE: begin
				if ((EXT_W'(DEPTH - 1) - fill_ext) < EXT_W'(blk_len)) begin
					chk_status = brb_pkg::ST_FULL;
				end
			end
			default: chk_status = brb_pkg::ST_OK;
		endcase
	end

	// shared adder: start address at accept, then address walk and final pointer
	always_comb begin
		if (state_q == S_IDLE) begin
			alu_base = rd_op ? rp_q : wp_q;
			alu_step = is_peek ? req.offset : '0;
		end else begin
			alu_base = addr_q;
			alu_step = brb_pkg::OFFSET_W'(1);
		end
	end

	brb_addr_unit #(
		.PTR_W(PTR_W)
	) u_addr (
		.base(alu_base),
		.step(alu_step),
		.sum (alu_sum)
	);

	brb_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (state_q == S_WR),
		.waddr(addr_q),
		.wdata(wbyte),
		.re   (state_q == S_RD),
		.raddr(addr_q),
		.rdata(rdata)
	);

	assign last_step = (LEN_W'(cnt_q) == (len_q - LEN_W'(1)));

	// byte lane of the write word for this step
	always_comb begin
		wbyte = '0;
		for (int i = 0; i < MAX_BLOCK; i++) begin
			if (IDX_W'(i) == cnt_q) wbyte = data_q[BYTE_W*i +: BYTE_W];
		end
	end

	// drop the byte coming back from the ram into its lane
	always_comb begin
		word_merged = word_q;
		for (int i = 0; i < MAX_BLOCK; i++) begin
			if (rvalid_s1 && (IDX_W'(i) == ridx_s1)) begin
				word_merged[BYTE_W*i +: BYTE_W] = rdata;
			end
		end
	end

	assign fill_rd_ext = EXT_W'(fill_q) - EXT_W'(len_q);
	assign fill_wr_ext = EXT_W'(fill_q) + EXT_W'(len_q);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			rp_q      <= '0;
			wp_q      <= '0;
			done_q    <= 1'b0;
			rvalid_s1 <= 1'b0;
		end else begin
			done_q    <= 1'b0;
			rvalid_s1 <= (state_q == S_RD);
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if ((chk_status != brb_pkg::ST_OK) || (len_eff == '0) ||
						    !(rd_op || wr_op)) begin
							done_q <= 1'b1;
						end else begin
							state_q <= rd_op ? S_RD : S_WR;
						end
					end
				end
				S_RD: begin
					if (last_step) state_q <= S_LAST;
				end
				S_LAST: begin
					if (upd_q) rp_q <= addr_q;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_WR: begin
					if (last_step) begin
						wp_q    <= alu_sum;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		ridx_s1 <= cnt_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					addr_q <= alu_sum;
					cnt_q  <= '0;
					len_q  <= len_eff;
					fill_q <= fill;
					data_q <= req.data_word;
					word_q <= '0;
					upd_q  <= !is_peek;
					// immediate result for failed, empty or unknown requests
					rsp_q.status     <= chk_status;
					rsp_q.read_word  <= '0;
					rsp_q.fill_level <= fill_ext[brb_pkg::FILL_W-1:0];
				end
			end
			S_RD: begin
				addr_q <= alu_sum;
				cnt_q  <= cnt_q + IDX_W'(1);
				word_q <= word_merged;
			end
			S_LAST: begin
				rsp_q.status     <= brb_pkg::ST_OK;
				rsp_q.read_word  <= word_merged;
				// a peek leaves the pointers alone, so the live count holds
				rsp_q.fill_level <= upd_q ? fill_rd_ext[brb_pkg::FILL_W-1:0]
				                          : fill_ext[brb_pkg::FILL_W-1:0];
			end
			S_WR: begin
				addr_q <= alu_sum;
				cnt_q  <= cnt_q + IDX_W'(1);
				rsp_q.status     <= brb_pkg::ST_OK;
				rsp_q.read_word  <= '0;
				rsp_q.fill_level <= fill_wr_ext[brb_pkg::FILL_W-1:0];
			end
			default: begin
				addr_q <= addr_q;
			end
		endcase
	end

`ifndef SYNTH
	// the read pointer only moves when a read sequence finishes
	a_rp_moves_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		$stable(rp_q) || ($past(state_q) == S_LAST))
		else $error("read pointer moved outside the read finish step");

	// the write pointer only moves on the last write step
	a_wp_moves_in_write: assert property (@(posedge clk) disable iff (!arst_n)
		$stable(wp_q) || ($past(state_q) == S_WR))
		else $error("write pointer moved outside a write step");

	// a result is never shown while a sequence is running
	a_done_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// the step count stays inside the request length
	a_cnt_in_len: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_RD) || (state_q == S_WR)) |-> (LEN_W'(cnt_q) < len_q))
		else $error("step count ran past the request length");
`endif

endmodule

`default_nettype wire

FILE: design/brb_ram.sv
// ----------------------------------------------------------------------------
// brb_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module brb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: design/brb_addr_unit.sv
// ----------------------------------------------------------------------------
// brb_addr_unit
// shared pointer adder, wraps modulo the power-of-two depth
// ----------------------------------------------------------------------------
`default_nettype none

module brb_addr_unit #(
	parameter int PTR_W = 8
) (
	input  wire logic [PTR_W-1:0]             base,
	input  wire logic [brb_pkg::OFFSET_W-1:0] step,
	output logic      [PTR_W-1:0]             sum
);

	localparam int EXT_W = (PTR_W > brb_pkg::OFFSET_W) ? PTR_W : brb_pkg::OFFSET_W;

	logic [EXT_W-1:0] sum_ext;

	// wide add, then drop the bits above the pointer for the wrap
	assign sum_ext = EXT_W'(base) + EXT_W'(step);
	assign sum     = sum_ext[PTR_W-1:0];

endmodule

`default_nettype wire
